// File: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the Q24.8 fixed-point ALU
// Opcodes, port widths and the control word that rides along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int OP_W       = 4;
  localparam int PORT_W     = 32;
  localparam int FRAC_BITS  = 8;
  localparam int DATA_WIDTH = 32;

  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
  localparam logic [OP_W-1:0] OP_GT   = 4'd4;
  localparam logic [OP_W-1:0] OP_LT   = 4'd5;
  localparam logic [OP_W-1:0] OP_GE   = 4'd6;
  localparam logic [OP_W-1:0] OP_LE   = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ   = 4'd8;
  localparam logic [OP_W-1:0] OP_NE   = 4'd9;
  localparam logic [OP_W-1:0] OP_MIN  = 4'd10;
  localparam logic [OP_W-1:0] OP_MAX  = 4'd11;
  localparam logic [OP_W-1:0] OP_INC  = 4'd12;
  localparam logic [OP_W-1:0] OP_DEC  = 4'd13;
  localparam logic [OP_W-1:0] OP_FINT = 4'd14;
  localparam logic [OP_W-1:0] OP_TINT = 4'd15;

  // Control word carried with each item down the chain
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic              flag;
    logic [PORT_W-1:0] value;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand decode and the non-divide operations
// Computes every non-divide result and primes the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front #(
  parameter int DW = 32,
  parameter int FB = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire logic [fpa_pkg::OP_W-1:0]       op,
  input  wire logic signed [fpa_pkg::PORT_W-1:0] operand_a,
  input  wire logic signed [fpa_pkg::PORT_W-1:0] operand_b,
  output fpa_pkg::ctl_t                       ctl_r,
  output logic [DW+FB-1:0]                    work_r,
  output logic [DW-1:0]                       dvs_r
);
  import fpa_pkg::*;

  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0]   a_w, b_w, v_w;
  logic signed [2*DW-1:0] prod;
  logic signed [2*DW-1:0] prod_sh;
  logic [DW-1:0]          a_mag, b_mag;
  ctl_t                   ctl_nxt;

  assign a_w     = operand_a[DW-1:0];
  assign b_w     = operand_b[DW-1:0];
  assign prod    = a_w * b_w;
  assign prod_sh = prod >>> FB;
  assign a_mag   = a_w[DW-1] ? DW'(-a_w) : DW'(a_w);
  assign b_mag   = b_w[DW-1] ? DW'(-b_w) : DW'(b_w);

  // Select the result of the non-divide operations
  always_comb begin
    v_w             = '0;
    ctl_nxt.valid   = take;
    ctl_nxt.is_div  = 1'b0;
    ctl_nxt.neg     = a_w[DW-1] ^ b_w[DW-1];
    ctl_nxt.flag    = 1'b0;
    case (op)
      OP_ADD:  v_w = a_w + b_w;
      OP_SUB:  v_w = a_w - b_w;
      OP_MUL:  v_w = prod_sh[DW-1:0];
      OP_DIV: begin
        ctl_nxt.is_div = 1'b1;
        ctl_nxt.flag   = (b_w == '0);
      end
      OP_GT:   ctl_nxt.flag = (a_w > b_w);
      OP_LT:   ctl_nxt.flag = (a_w < b_w);
      OP_GE:   ctl_nxt.flag = (a_w >= b_w);
      OP_LE:   ctl_nxt.flag = (a_w <= b_w);
      OP_EQ:   ctl_nxt.flag = (a_w == b_w);
      OP_NE:   ctl_nxt.flag = (a_w != b_w);
      OP_MIN:  v_w = (a_w > b_w) ? b_w : a_w;
      OP_MAX:  v_w = (a_w < b_w) ? b_w : a_w;
      OP_INC:  v_w = (a_w != WMAX) ? a_w + 1'b1 : a_w;
      OP_DEC:  v_w = (a_w != WMIN) ? a_w - 1'b1 : a_w;
      OP_FINT: v_w = a_w <<< FB;
      OP_TINT: v_w = a_w >>> FB;
      default: v_w = '0;
    endcase
    ctl_nxt.value = PORT_W'(v_w);
  end

  // Register the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.is_div <= ctl_nxt.is_div;
    ctl_r.neg    <= ctl_nxt.neg;
    ctl_r.flag   <= ctl_nxt.flag;
    ctl_r.value  <= ctl_nxt.value;
    work_r       <= {a_mag, {FB{1'b0}}};
    dvs_r        <= b_mag;
  end

endmodule

`default_nettype wire

// File: rtl/core/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division cell
// Retires one quotient bit per cell and hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell #(
  parameter int DW = 32,
  parameter int FB = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fpa_pkg::ctl_t ctl_in,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [DW+FB-1:0] work_in,
  input  wire logic [DW-1:0] dvs_in,
  output fpa_pkg::ctl_t      ctl_r,
  output logic [DW-1:0]      rem_r,
  output logic [DW+FB-1:0]   work_r,
  output logic [DW-1:0]      dvs_r
);
  import fpa_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_in, work_in[DW+FB-1]};
  assign diff  = trial - {1'b0, dvs_in};
  assign ge    = !diff[DW];

  // Advance remainder, dividend bits out the top, quotient bits in the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.is_div <= ctl_in.is_div;
    ctl_r.neg    <= ctl_in.neg;
    ctl_r.flag   <= ctl_in.flag;
    ctl_r.value  <= ctl_in.value;
    rem_r        <= ge ? diff[DW-1:0] : trial[DW-1:0];
    work_r       <= {work_in[DW+FB-2:0], ge};
    dvs_r        <= dvs_in;
  end

endmodule

`default_nettype wire

// File: rtl/core/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result stage
// Applies the quotient sign, picks the final value and drives the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back #(
  parameter int DW = 32,
  parameter int FB = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fpa_pkg::ctl_t            ctl_in,
  input  wire logic [DW+FB-1:0]         work_in,
  output logic                          valid_r,
  output logic [fpa_pkg::PORT_W-1:0]    value_r,
  output logic                          flag_r
);
  import fpa_pkg::*;

  logic [DW-1:0]        q;
  logic signed [DW-1:0] q_s;

  // Sign the quotient magnitude, keep the low word
  assign q   = work_in[DW-1:0];
  assign q_s = ctl_in.neg ? DW'(~q + 1'b1) : q;

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_in.valid;
    end
    flag_r  <= ctl_in.flag;
    value_r <= (ctl_in.is_div && !ctl_in.flag) ? PORT_W'(q_s) : ctl_in.value;
  end

endmodule

`default_nettype wire

// File: rtl/core/fixed_point_alu_q24_8_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core: signed Q24.8 fixed-point ALU
// Add, sub, mul, div, compares, min/max, saturating inc/dec, int conversion.
// ----------------------------------------------------------------------------
// Takes one operation every clock: busy stays low. Every result appears on
// out_value/out_flag for one cycle with out_valid, in issue order. Each
// item passes the front stage, the divider (a row of restoring cells that
// each retire one quotient bit) and the result stage; all operations travel
// through that row so order holds. The receiver cannot stall, so results
// must be captured when out_valid is high.
`default_nettype none

module fixed_point_alu_q24_8_core #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fpa_pkg::OP_W-1:0]          in_op,
  input  wire logic signed [fpa_pkg::PORT_W-1:0] in_operand_a,
  input  wire logic signed [fpa_pkg::PORT_W-1:0] in_operand_b,
  output logic                                   out_valid,
  output logic signed [fpa_pkg::PORT_W-1:0]      out_value,
  output logic                                   out_flag
);
  import fpa_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NC = DW + FB;

  ctl_t             chain_ctl  [NC+1];
  logic [DW-1:0]    chain_rem  [NC+1];
  logic [DW+FB-1:0] chain_work [NC+1];
  logic [DW-1:0]    chain_dvs  [NC+1];

  assign busy         = 1'b0;
  assign chain_rem[0] = '0;

  fpa_front #(.DW(DW), .FB(FB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .op        (in_op),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .ctl_r     (chain_ctl[0]),
    .work_r    (chain_work[0]),
    .dvs_r     (chain_dvs[0])
  );

  // Division cells, one quotient bit each
  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_div_cell #(.DW(DW), .FB(FB)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (chain_ctl[i]),
      .rem_in  (chain_rem[i]),
      .work_in (chain_work[i]),
      .dvs_in  (chain_dvs[i]),
      .ctl_r   (chain_ctl[i+1]),
      .rem_r   (chain_rem[i+1]),
      .work_r  (chain_work[i+1]),
      .dvs_r   (chain_dvs[i+1])
    );
  end

  fpa_back #(.DW(DW), .FB(FB)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (chain_ctl[NC]),
    .work_in (chain_work[NC]),
    .valid_r (out_valid),
    .value_r (out_value),
    .flag_r  (out_flag)
  );

  // Items are neither dropped nor created in the first cell of the chain
  a_chain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (chain_ctl[1].valid == $past(chain_ctl[0].valid)))
    else $error("cell chain lost or created an item");

  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(chain_ctl[NC].valid)))
    else $error("result strobe does not follow the last cell");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (chain_ctl[0].valid == $past(start)))
    else $error("accepted start did not enter the chain");

endmodule

`default_nettype wire

// File: tb/sv/fixed_point_alu_q24_8_core_test.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core_test: self-checking bench for the Q24.8 ALU
// Drives directed corner operations and bursty random traffic, predicts each
// result in-bench and compares every output transfer in issue order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_alu_q24_8_core_test;
  import fpa_pkg::*;

  localparam int LATENCY   = DATA_WIDTH + FRAC_BITS + 2;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [PORT_W-1:0] a;
    logic signed [PORT_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic signed [PORT_W-1:0] value;
    logic                     flag;
  } alu_res_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          in_op;
  logic signed [PORT_W-1:0] in_operand_a;
  logic signed [PORT_W-1:0] in_operand_b;
  logic                     out_valid;
  logic signed [PORT_W-1:0] out_value;
  logic                     out_flag;

  alu_op_t  op_queue[$];
  alu_res_t result_queue[$];
  int       mismatches;
  int       idle_cycles;
  int       burst_left;
  int       gap_left;
  bit       stim_done;
  bit       hold_drain;

  fixed_point_alu_q24_8_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_flag     (out_flag)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Compute the expected result of one operation
  function automatic alu_res_t alu_predict(alu_op_t t);
    alu_res_t            r;
    logic signed [63:0]  a64;
    logic signed [63:0]  b64;
    logic signed [63:0]  wide;
    a64 = t.a;
    b64 = t.b;
    r.value = '0;
    r.flag  = 1'b0;
    case (t.op)
      OP_ADD: r.value = t.a + t.b;
      OP_SUB: r.value = t.a - t.b;
      OP_MUL: begin
        wide = (a64 * b64) >>> FRAC_BITS;
        r.value = wide[PORT_W-1:0];
      end
      OP_DIV: begin
        if (t.b == 0) begin
          r.flag = 1'b1;
        end else begin
          wide = (a64 <<< FRAC_BITS) / b64;
          r.value = wide[PORT_W-1:0];
        end
      end
      OP_GT:  r.flag = t.a > t.b;
      OP_LT:  r.flag = t.a < t.b;
      OP_GE:  r.flag = t.a >= t.b;
      OP_LE:  r.flag = t.a <= t.b;
      OP_EQ:  r.flag = t.a == t.b;
      OP_NE:  r.flag = t.a != t.b;
      OP_MIN: r.value = (t.a > t.b) ? t.b : t.a;
      OP_MAX: r.value = (t.a < t.b) ? t.b : t.a;
      OP_INC: r.value = (t.a != 32'sh7fffffff) ? t.a + 1 : t.a;
      OP_DEC: r.value = (t.a != 32'sh80000000) ? t.a - 1 : t.a;
      OP_FINT: r.value = t.a <<< FRAC_BITS;
      default: r.value = t.a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  // Pick an operand, weighted toward corners and small magnitudes
  function automatic logic [PORT_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) - 1;
      3, 4: return $urandom_range(0, 8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_op_t mk_op(logic [OP_W-1:0] op, logic [PORT_W-1:0] a,
                                    logic [PORT_W-1:0] b);
    alu_op_t t;
    t.op = op;
    t.a  = a;
    t.b  = b;
    return t;
  endfunction

  // Fill the stimulus queue
  initial begin
    alu_op_t t;
    int      i;
    op_queue.push_back(mk_op(OP_ADD, 32'h7fffffff, 32'h1));
    op_queue.push_back(mk_op(OP_SUB, 32'h80000000, 32'h1));
    op_queue.push_back(mk_op(OP_MUL, 32'h80000000, 32'h80000000));
    op_queue.push_back(mk_op(OP_MUL, 32'hffffff00, 32'h00000180));
    op_queue.push_back(mk_op(OP_DIV, 32'h00000300, 32'h0));
    op_queue.push_back(mk_op(OP_DIV, 32'h80000000, 32'hffffffff));
    op_queue.push_back(mk_op(OP_DIV, 32'hfffffd00, 32'h00000200));
    op_queue.push_back(mk_op(OP_GT, 32'h5, 32'h5));
    op_queue.push_back(mk_op(OP_LT, 32'h80000000, 32'h7fffffff));
    op_queue.push_back(mk_op(OP_GE, 32'h5, 32'h5));
    op_queue.push_back(mk_op(OP_LE, 32'h7fffffff, 32'h80000000));
    op_queue.push_back(mk_op(OP_EQ, 32'hffffffff, 32'hffffffff));
    op_queue.push_back(mk_op(OP_NE, 32'h0, 32'h0));
    op_queue.push_back(mk_op(OP_MIN, 32'h80000000, 32'h80000000));
    op_queue.push_back(mk_op(OP_MAX, 32'h80000000, 32'h7fffffff));
    op_queue.push_back(mk_op(OP_INC, 32'h7fffffff, 32'hffffffff));
    op_queue.push_back(mk_op(OP_DEC, 32'h80000000, 32'h0));
    op_queue.push_back(mk_op(OP_INC, 32'hffffffff, 32'h0));
    op_queue.push_back(mk_op(OP_FINT, 32'h00ffffff, 32'h0));
    op_queue.push_back(mk_op(OP_FINT, 32'h80000001, 32'h0));
    op_queue.push_back(mk_op(OP_TINT, 32'hffffff01, 32'h0));
    op_queue.push_back(mk_op(OP_TINT, 32'h7fffffff, 32'h0));
    for (i = 0; i < 1030; i++) begin
      t.op = $urandom_range(0, 15);
      t.a  = pick_operand();
      t.b  = ($urandom_range(0, 7) == 0) ? t.a : pick_operand();
      op_queue.push_back(t);
    end
  end

  // Drive start and operands in random bursts; drain once midway
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
      hold_drain <= 1'b0;
      stim_done  <= 1'b0;
    end else begin
      if (start && !busy) begin
        result_queue.push_back(alu_predict(mk_op(in_op, in_operand_a, in_operand_b)));
        void'(op_queue.pop_front());
        if (op_queue.size() == 500) hold_drain <= 1'b1;
      end
      if (hold_drain && !(start && !busy) && result_queue.size() == 0) hold_drain <= 1'b0;
      if (op_queue.size() == 0) begin
        start     <= 1'b0;
        stim_done <= 1'b1;
      end else if (hold_drain || (start && !busy && op_queue.size() == 500)) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (start && !busy && burst_left <= 1) begin
        // End the burst and pick the next one
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        start      <= 1'b0;
      end else begin
        start        <= 1'b1;
        in_op        <= op_queue[0].op;
        in_operand_a <= op_queue[0].a;
        in_operand_b <= op_queue[0].b;
        if (start && !busy) burst_left <= burst_left - 1;
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h flag=%b", out_value, out_flag);
      end else begin
        if (out_value !== result_queue[0].value || out_flag !== result_queue[0].flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value=%h flag=%b, got value=%h flag=%b",
                     result_queue[0].value, result_queue[0].flag, out_value, out_flag);
        end
        void'(result_queue.pop_front());
      end
    end
  end

  // Count cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatches   = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b0;
    @(negedge clk);
    rst_n = 1'b1;
    while (!(stim_done && result_queue.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      if (mismatches == 0 && result_queue.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
    end
    $finish;
  end

endmodule
